### rtl/owbm_pkg.sv
`timescale 1ns / 1ps
package owbm_pkg;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int REQ_W     = 3;
    localparam int BYTE_W    = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK       = 3'd0,
        REQ_RESET      = 3'd1,
        REQ_WRITE_BYTE = 3'd2,
        REQ_READ_BYTE  = 3'd3,
        REQ_WRITE_BIT  = 3'd4,
        REQ_READ_BIT   = 3'd5
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW      = 3'd0,
        CFG_PRESENCE_DELAY = 3'd1,
        CFG_PRESENCE_WIN   = 3'd2,
        CFG_WRITE0_LOW     = 3'd3,
        CFG_WRITE1_LOW     = 3'd4,
        CFG_READ_LOW       = 3'd5,
        CFG_SLOT_RECOVERY  = 3'd6,
        CFG_BIT_GAP        = 3'd7
    } cfg_idx_t;

    localparam logic [9:0] RESET_LOW_DEF      = 10'd500;
    localparam logic [7:0] PRESENCE_DELAY_DEF = 8'd50;
    localparam logic [9:0] PRESENCE_WIN_DEF   = 10'd500;
    localparam logic [7:0] WRITE0_LOW_DEF     = 8'd80;
    localparam logic [7:0] WRITE1_LOW_DEF     = 8'd1;
    localparam logic [7:0] READ_LOW_DEF       = 8'd3;
    localparam logic [7:0] SLOT_RECOVERY_DEF  = 8'd80;
    localparam logic [7:0] BIT_GAP_DEF        = 8'd1;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_RST_LOW   = 9'b000000010,
        PH_RST_WAIT  = 9'b000000100,
        PH_RST_WATCH = 9'b000001000,
        PH_RST_RISE  = 9'b000010000,
        PH_SLOT_LOW  = 9'b000100000,
        PH_SAMPLE    = 9'b001000000,
        PH_REC       = 9'b010000000,
        PH_GAP       = 9'b100000000
    } phase_t;

endpackage

### rtl/one_wire_bus_master.sv
`timescale 1ns / 1ps
// result: an accepted input beat's result beat is presented in the next cycle
// throughput: one tick beat per cycle unless the output stalls; the bus sequencer
// and its timer update in the same cycle the tick is taken, the result sits in the output register
// reset: synchronous active-low aresetn returns the sequencer to idle, clears
// presence and read data and loads the default timing registers
module one_wire_bus_master #(
    parameter int TIMER_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] data_in, [8] bus_level, [15:9] zero
    input  logic [15:0] s_tdata,
    // [2:0] req_type
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence, [11:4] read_data,
    // [15:12] zero
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);

    logic [9:0] reset_low_reg, presence_win_reg;
    logic [7:0] presence_delay_reg, write0_low_reg, write1_low_reg;
    logic [7:0] read_low_reg, slot_recovery_reg, bit_gap_reg;

    owbm_pkg::phase_t        phase_reg, phase_next;
    logic [TIMER_BITS-1:0]   timer_reg, timer_next;
    logic [2:0]              bit_index_reg, bit_index_next;
    logic                    single_reg, single_next;
    logic [7:0]              shift_reg, shift_next;
    logic                    presence_reg, presence_next;
    logic                    is_read_reg, is_read_next;
    logic [7:0]              read_reg, read_next;
    logic                    drive_next, busy_next, done_next;

    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    logic       accept;
    logic [2:0] req;
    logic [7:0] din;
    logic       lvl;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign req      = s_tuser;
    assign din      = s_tdata[7:0];
    assign lvl      = s_tdata[8];

    function automatic logic [TIMER_BITS-1:0] load_timer(input logic [9:0] len);
        logic [9:0] m;
        m = (len != 10'd0) ? len - 10'd1 : 10'd0;
        return TIMER_BITS'(m);
    endfunction

    always_comb begin
        logic expired;
        logic end_slot;
        logic finish;
        logic [7:0] slen;
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        bit_index_next = bit_index_reg;
        single_next    = single_reg;
        shift_next     = shift_reg;
        presence_next  = presence_reg;
        is_read_next   = is_read_reg;
        read_next      = read_reg;
        drive_next     = 1'b0;
        busy_next      = 1'b0;
        done_next      = 1'b0;
        end_slot       = 1'b0;
        finish         = 1'b0;
        expired        = 1'b0;
        slen           = 8'd0;

        if (phase_next == owbm_pkg::PH_IDLE) begin
            case (req)
                owbm_pkg::REQ_RESET: begin
                    phase_next = owbm_pkg::PH_RST_LOW;
                    timer_next = load_timer(reset_low_reg);
                end
                owbm_pkg::REQ_WRITE_BYTE, owbm_pkg::REQ_READ_BYTE,
                owbm_pkg::REQ_WRITE_BIT, owbm_pkg::REQ_READ_BIT: begin
                    is_read_next   = (req == owbm_pkg::REQ_READ_BYTE) ||
                                     (req == owbm_pkg::REQ_READ_BIT);
                    single_next    = (req == owbm_pkg::REQ_WRITE_BIT) ||
                                     (req == owbm_pkg::REQ_READ_BIT);
                    bit_index_next = 3'd0;
                    shift_next     = is_read_next ? 8'd0 : din;
                    slen           = is_read_next ? read_low_reg :
                                     (shift_next[0] ? write1_low_reg : write0_low_reg);
                    phase_next     = owbm_pkg::PH_SLOT_LOW;
                    timer_next     = load_timer({2'b00, slen});
                end
                default: begin
                end
            endcase
        end

        if (phase_next != owbm_pkg::PH_IDLE) begin
            busy_next  = 1'b1;
            drive_next = (phase_next == owbm_pkg::PH_RST_LOW) ||
                         (phase_next == owbm_pkg::PH_SLOT_LOW);
            expired    = (timer_next == '0);
            if (!expired) begin
                timer_next = timer_next - TIMER_BITS'(1);
            end
            case (phase_next)
                owbm_pkg::PH_RST_LOW: begin
                    if (expired) begin
                        phase_next = owbm_pkg::PH_RST_WAIT;
                        timer_next = load_timer({2'b00, presence_delay_reg});
                    end
                end
                owbm_pkg::PH_RST_WAIT: begin
                    if (expired) begin
                        phase_next = owbm_pkg::PH_RST_WATCH;
                        timer_next = load_timer(presence_win_reg);
                    end
                end
                owbm_pkg::PH_RST_WATCH: begin
                    if (!lvl) begin
                        phase_next = owbm_pkg::PH_RST_RISE;
                        timer_next = '0;
                    end else if (expired) begin
                        is_read_next  = 1'b0;
                        presence_next = 1'b0;
                        finish        = 1'b1;
                    end
                end
                owbm_pkg::PH_RST_RISE: begin
                    if (lvl) begin
                        is_read_next  = 1'b0;
                        presence_next = 1'b1;
                        finish        = 1'b1;
                    end
                end
                owbm_pkg::PH_SLOT_LOW: begin
                    if (expired) begin
                        if (is_read_next) begin
                            phase_next = owbm_pkg::PH_SAMPLE;
                            timer_next = '0;
                        end else if (shift_next[0]) begin
                            phase_next = owbm_pkg::PH_REC;
                            timer_next = load_timer({2'b00, slot_recovery_reg});
                        end else begin
                            end_slot = 1'b1;
                        end
                    end
                end
                owbm_pkg::PH_SAMPLE: begin
                    if (single_next) begin
                        shift_next = {7'd0, lvl};
                    end else begin
                        shift_next = {lvl, shift_next[7:1]};
                    end
                    if (slot_recovery_reg <= 8'd1) begin
                        end_slot = 1'b1;
                    end else begin
                        phase_next = owbm_pkg::PH_REC;
                        timer_next = load_timer({2'b00, slot_recovery_reg - 8'd1});
                    end
                end
                owbm_pkg::PH_REC: begin
                    if (expired) begin
                        end_slot = 1'b1;
                    end
                end
                owbm_pkg::PH_GAP: begin
                    if (expired) begin
                        if (bit_index_next >= owbm_pkg::LAST_BIT) begin
                            finish = 1'b1;
                        end else begin
                            bit_index_next = bit_index_next + 3'd1;
                            slen = is_read_next ? read_low_reg :
                                   (shift_next[0] ? write1_low_reg : write0_low_reg);
                            phase_next = owbm_pkg::PH_SLOT_LOW;
                            timer_next = load_timer({2'b00, slen});
                        end
                    end
                end
                default: begin
                    phase_next = owbm_pkg::PH_IDLE;
                    timer_next = '0;
                end
            endcase

            if (end_slot) begin
                if (!is_read_next) begin
                    shift_next = {1'b0, shift_next[7:1]};
                end
                if (single_next) begin
                    finish = 1'b1;
                end else begin
                    phase_next = owbm_pkg::PH_GAP;
                    timer_next = load_timer({2'b00, bit_gap_reg});
                end
            end

            if (finish) begin
                if (is_read_next) begin
                    read_next = shift_next;
                end
                phase_next = owbm_pkg::PH_IDLE;
                timer_next = '0;
                done_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= owbm_pkg::PH_IDLE;
            timer_reg     <= '0;
            bit_index_reg <= 3'd0;
            single_reg    <= 1'b0;
            shift_reg     <= 8'd0;
            presence_reg  <= 1'b0;
            is_read_reg   <= 1'b0;
            read_reg      <= 8'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                timer_reg     <= timer_next;
                bit_index_reg <= bit_index_next;
                single_reg    <= single_next;
                shift_reg     <= shift_next;
                presence_reg  <= presence_next;
                is_read_reg   <= is_read_next;
                read_reg      <= read_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {4'd0, read_next, presence_next, done_next, busy_next, drive_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg      <= owbm_pkg::RESET_LOW_DEF;
            presence_delay_reg <= owbm_pkg::PRESENCE_DELAY_DEF;
            presence_win_reg   <= owbm_pkg::PRESENCE_WIN_DEF;
            write0_low_reg     <= owbm_pkg::WRITE0_LOW_DEF;
            write1_low_reg     <= owbm_pkg::WRITE1_LOW_DEF;
            read_low_reg       <= owbm_pkg::READ_LOW_DEF;
            slot_recovery_reg  <= owbm_pkg::SLOT_RECOVERY_DEF;
            bit_gap_reg        <= owbm_pkg::BIT_GAP_DEF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                owbm_pkg::CFG_RESET_LOW:      reset_low_reg      <= cfg_wdata;
                owbm_pkg::CFG_PRESENCE_DELAY: presence_delay_reg <= cfg_wdata[7:0];
                owbm_pkg::CFG_PRESENCE_WIN:   presence_win_reg   <= cfg_wdata;
                owbm_pkg::CFG_WRITE0_LOW:     write0_low_reg     <= cfg_wdata[7:0];
                owbm_pkg::CFG_WRITE1_LOW:     write1_low_reg     <= cfg_wdata[7:0];
                owbm_pkg::CFG_READ_LOW:       read_low_reg       <= cfg_wdata[7:0];
                owbm_pkg::CFG_SLOT_RECOVERY:  slot_recovery_reg  <= cfg_wdata[7:0];
                owbm_pkg::CFG_BIT_GAP:        bit_gap_reg        <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // idle sequencer never holds a running timer
    a_idle_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == owbm_pkg::PH_IDLE) |-> (timer_reg == '0))
        else $error("timer nonzero while idle");

    // single bit transfers never advance the bit counter
    a_single_index: assert property (@(posedge aclk) disable iff (!aresetn)
        single_reg |-> (bit_index_reg == 3'd0))
        else $error("bit index moved in single bit mode");

    // a finishing beat is always a busy beat
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[2]) |-> m_data_reg[1])
        else $error("done without busy");

    // busy result beat matches the sequencer state it left behind
    a_busy_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[1]) |-> (phase_reg == owbm_pkg::PH_IDLE))
        else $error("idle beat but sequencer active");

endmodule

### dv/owbm_line_checker.sv
`timescale 1ns / 1ps
module owbm_line_checker #(
    parameter int TIMER_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [7:0] data_in, [8] bus_level, [15:9] zero
    input  logic [15:0] s_tdata,
    // [2:0] req_type
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence, [11:4] read_data
    input  logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_wdata,
    output int          mismatches,
    output int          pending,
    output logic        line_idle
);

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_data;
    } line_result_t;

    line_result_t expected_lines[$];

    logic [9:0]            timing [8];
    owbm_pkg::phase_t      ph;
    logic [TIMER_BITS-1:0] tmr;
    logic [2:0]            bit_pos;
    logic                  one_bit;
    logic [7:0]            shreg;
    logic                  presence_q;
    logic                  reading;
    logic [7:0]            rd_byte;
    logic                  done_q;

    function void load_phase(owbm_pkg::phase_t p, logic [9:0] len);
        ph  = p;
        tmr = (len != 10'd0) ? TIMER_BITS'(len - 10'd1) : '0;
    endfunction

    function void complete_op();
        if (reading) begin
            rd_byte = shreg;
        end
        ph     = owbm_pkg::PH_IDLE;
        tmr    = '0;
        done_q = 1'b1;
    endfunction

    function void open_slot();
        logic [9:0] len;
        if (reading) begin
            len = timing[owbm_pkg::CFG_READ_LOW];
        end else if (shreg[0]) begin
            len = timing[owbm_pkg::CFG_WRITE1_LOW];
        end else begin
            len = timing[owbm_pkg::CFG_WRITE0_LOW];
        end
        load_phase(owbm_pkg::PH_SLOT_LOW, len);
    endfunction

    function void close_slot();
        if (!reading) begin
            shreg = shreg >> 1;
        end
        if (one_bit) begin
            complete_op();
        end else begin
            load_phase(owbm_pkg::PH_GAP, timing[owbm_pkg::CFG_BIT_GAP]);
        end
    endfunction

    function line_result_t predict_tick(logic [2:0] req, logic [7:0] dat, logic lvl);
        line_result_t r;
        logic         expired;
        logic         drv;
        logic         bsy;
        done_q = 1'b0;
        drv    = 1'b0;
        bsy    = 1'b0;
        if (ph == owbm_pkg::PH_IDLE) begin
            if (req == owbm_pkg::REQ_RESET) begin
                load_phase(owbm_pkg::PH_RST_LOW, timing[owbm_pkg::CFG_RESET_LOW]);
            end else if (req == owbm_pkg::REQ_WRITE_BYTE || req == owbm_pkg::REQ_READ_BYTE ||
                         req == owbm_pkg::REQ_WRITE_BIT || req == owbm_pkg::REQ_READ_BIT) begin
                reading = (req == owbm_pkg::REQ_READ_BYTE || req == owbm_pkg::REQ_READ_BIT);
                one_bit = (req == owbm_pkg::REQ_WRITE_BIT || req == owbm_pkg::REQ_READ_BIT);
                bit_pos = 3'd0;
                shreg   = reading ? 8'h00 : dat;
                open_slot();
            end
        end
        if (ph != owbm_pkg::PH_IDLE) begin
            bsy     = 1'b1;
            drv     = (ph == owbm_pkg::PH_RST_LOW || ph == owbm_pkg::PH_SLOT_LOW);
            expired = (tmr == '0);
            if (!expired) begin
                tmr = tmr - 1'b1;
            end
            case (ph)
                owbm_pkg::PH_RST_LOW: begin
                    if (expired) begin
                        load_phase(owbm_pkg::PH_RST_WAIT,
                                   timing[owbm_pkg::CFG_PRESENCE_DELAY]);
                    end
                end
                owbm_pkg::PH_RST_WAIT: begin
                    if (expired) begin
                        load_phase(owbm_pkg::PH_RST_WATCH,
                                   timing[owbm_pkg::CFG_PRESENCE_WIN]);
                    end
                end
                owbm_pkg::PH_RST_WATCH: begin
                    if (!lvl) begin
                        load_phase(owbm_pkg::PH_RST_RISE, 10'd0);
                    end else if (expired) begin
                        reading    = 1'b0;
                        presence_q = 1'b0;
                        complete_op();
                    end
                end
                owbm_pkg::PH_RST_RISE: begin
                    if (lvl) begin
                        reading    = 1'b0;
                        presence_q = 1'b1;
                        complete_op();
                    end
                end
                owbm_pkg::PH_SLOT_LOW: begin
                    if (expired) begin
                        if (reading) begin
                            load_phase(owbm_pkg::PH_SAMPLE, 10'd0);
                        end else if (shreg[0]) begin
                            load_phase(owbm_pkg::PH_REC,
                                       timing[owbm_pkg::CFG_SLOT_RECOVERY]);
                        end else begin
                            close_slot();
                        end
                    end
                end
                owbm_pkg::PH_SAMPLE: begin
                    if (one_bit) begin
                        shreg = {7'd0, lvl};
                    end else begin
                        shreg = {lvl, shreg[7:1]};
                    end
                    if (timing[owbm_pkg::CFG_SLOT_RECOVERY] <= 10'd1) begin
                        close_slot();
                    end else begin
                        load_phase(owbm_pkg::PH_REC,
                                   timing[owbm_pkg::CFG_SLOT_RECOVERY] - 10'd1);
                    end
                end
                owbm_pkg::PH_REC: begin
                    if (expired) close_slot();
                end
                owbm_pkg::PH_GAP: begin
                    if (expired) begin
                        if (bit_pos >= owbm_pkg::LAST_BIT) begin
                            complete_op();
                        end else begin
                            bit_pos = bit_pos + 3'd1;
                            open_slot();
                        end
                    end
                end
                default: begin
                    ph  = owbm_pkg::PH_IDLE;
                    tmr = '0;
                end
            endcase
        end
        r.drive_low = drv;
        r.busy      = bsy;
        r.done      = done_q;
        r.presence  = presence_q;
        r.read_data = rd_byte;
        return r;
    endfunction

    task automatic report_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        line_result_t want;
        line_result_t got;
        if (!aresetn) begin
            timing[owbm_pkg::CFG_RESET_LOW]      = owbm_pkg::RESET_LOW_DEF;
            timing[owbm_pkg::CFG_PRESENCE_DELAY] = {2'b00, owbm_pkg::PRESENCE_DELAY_DEF};
            timing[owbm_pkg::CFG_PRESENCE_WIN]   = owbm_pkg::PRESENCE_WIN_DEF;
            timing[owbm_pkg::CFG_WRITE0_LOW]     = {2'b00, owbm_pkg::WRITE0_LOW_DEF};
            timing[owbm_pkg::CFG_WRITE1_LOW]     = {2'b00, owbm_pkg::WRITE1_LOW_DEF};
            timing[owbm_pkg::CFG_READ_LOW]       = {2'b00, owbm_pkg::READ_LOW_DEF};
            timing[owbm_pkg::CFG_SLOT_RECOVERY]  = {2'b00, owbm_pkg::SLOT_RECOVERY_DEF};
            timing[owbm_pkg::CFG_BIT_GAP]        = {2'b00, owbm_pkg::BIT_GAP_DEF};
            ph         = owbm_pkg::PH_IDLE;
            tmr        = '0;
            bit_pos    = 3'd0;
            one_bit    = 1'b0;
            shreg      = 8'h00;
            presence_q = 1'b0;
            reading    = 1'b0;
            rd_byte    = 8'h00;
            done_q     = 1'b0;
            expected_lines.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_lines.push_back(predict_tick(s_tuser, s_tdata[7:0], s_tdata[8]));
            end
            if (cfg_wr_en) begin
                if (cfg_index == owbm_pkg::CFG_RESET_LOW ||
                    cfg_index == owbm_pkg::CFG_PRESENCE_WIN) begin
                    timing[cfg_index] = cfg_wdata;
                end else begin
                    timing[cfg_index] = {2'b00, cfg_wdata[7:0]};
                end
            end
            if (m_tvalid && m_tready) begin
                got.drive_low = m_tdata[0];
                got.busy      = m_tdata[1];
                got.done      = m_tdata[2];
                got.presence  = m_tdata[3];
                got.read_data = m_tdata[11:4];
                if (expected_lines.size() == 0) begin
                    $display("%0t: result beat expected none actual %0h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_lines.pop_front();
                    report_field("drive_low", want.drive_low, got.drive_low);
                    report_field("busy", want.busy, got.busy);
                    report_field("done", want.done, got.done);
                    report_field("presence", want.presence, got.presence);
                    report_field("read_data", want.read_data, got.read_data);
                end
            end
        end
        pending   = expected_lines.size();
        line_idle = (ph == owbm_pkg::PH_IDLE);
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int TIMER_BITS  = 10;
    localparam int QUIET_LIMIT = 1000;
    localparam int STUCK_TICKS = 64;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    typedef enum int {LV_HIGH, LV_LOW, LV_RANDOM, LV_RARE_LOW, LV_RUNS} lv_mode_t;
    typedef enum int {TM_ZERO, TM_SMALL} timing_kind_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [9:0]  cfg_wdata = '0;

    int   mismatches;
    int   pending;
    logic line_idle;

    logic gaps_on       = 1'b1;
    int   rx_stall_left = 0;
    int   quiet_cycles  = 0;
    int   n_cmds        = 0;
    int   n_ticks       = 0;
    int   n_setups      = 0;
    int   run_left      = 0;
    logic run_lvl       = 1'b1;

    one_wire_bus_master #(
        .TIMER_BITS(TIMER_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    owbm_line_checker #(
        .TIMER_BITS(TIMER_BITS)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .mismatches(mismatches),
        .pending   (pending),
        .line_idle (line_idle)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(negedge aclk) begin
        if (rx_stall_left != 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 15) == 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // bus level seen by the master; forced high late in a command so a stuck line clears
    function logic bus_sample(lv_mode_t m, int n);
        if (n >= STUCK_TICKS) begin
            return 1'b1;
        end
        case (m)
            LV_HIGH:     return 1'b1;
            LV_LOW:      return 1'b0;
            LV_RANDOM:   return 1'($urandom_range(0, 1));
            LV_RARE_LOW: return ($urandom_range(0, 15) != 0);
            default: begin
                if (run_left == 0) begin
                    run_lvl  = ~run_lvl;
                    run_left = $urandom_range(1, 40);
                end
                run_left--;
                return run_lvl;
            end
        endcase
    endfunction

    task automatic send_beat(logic [2:0] req, logic [7:0] dat, logic lvl);
        if (gaps_on && $urandom_range(0, 11) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, lvl, dat};
        do @(posedge aclk); while (!s_tready);
        n_ticks++;
        @(negedge aclk);
    endtask

    task automatic run_cmd(logic [2:0] req, logic [7:0] dat, lv_mode_t m, logic noise);
        int         n;
        logic [2:0] rq;
        send_beat(req, dat, bus_sample(m, 0));
        n = 1;
        while (!line_idle) begin
            rq = (noise && $urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) :
                 owbm_pkg::REQ_TICK;
            send_beat(rq, 8'($urandom), bus_sample(m, n));
            n++;
        end
        n_cmds++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    task automatic set_timing(timing_kind_t kind);
        logic [9:0] val;
        drain_results();
        repeat (2) @(negedge aclk);
        for (int i = 0; i < 8; i++) begin
            case (kind)
                TM_ZERO:  val = 10'd0;
                default:  val = 10'($urandom_range(0, 6));
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= owbm_pkg::cfg_idx_t'(i);
            cfg_wdata <= val;
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        n_setups++;
    endtask

    initial begin
        timing_kind_t kind;
        int           pick;
        logic [2:0]   rq;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // power-on timing
        run_cmd(owbm_pkg::REQ_WRITE_BIT, 8'h01, LV_HIGH, 1'b0);
        run_cmd(owbm_pkg::REQ_READ_BIT, 8'h00, LV_RANDOM, 1'b1);
        run_cmd(REQ_SPARE_6, 8'h3C, LV_LOW, 1'b0);
        run_cmd(REQ_SPARE_7, 8'hC3, LV_HIGH, 1'b0);
        run_cmd(owbm_pkg::REQ_TICK, 8'h00, LV_LOW, 1'b0);

        for (int p = 0; p < 6; p++) begin
            kind = (p == 0 || p == 4) ? TM_ZERO : TM_SMALL;
            set_timing(kind);
            gaps_on = (p != 5);
            for (int t = 0; t < 5; t++) begin
                pick = $urandom_range(0, 15);
                if (pick < 2) begin
                    case ($urandom_range(0, 2))
                        0:       rq = owbm_pkg::REQ_TICK;
                        1:       rq = REQ_SPARE_6;
                        default: rq = REQ_SPARE_7;
                    endcase
                end else begin
                    rq = 3'($urandom_range(owbm_pkg::REQ_RESET, owbm_pkg::REQ_READ_BIT));
                end
                run_cmd(rq, 8'($urandom), lv_mode_t'($urandom_range(0, 4)),
                        $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 31) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (4) @(negedge aclk);
        $display("ran %0d commands over %0d bus ticks across %0d timing setups plus power-on",
                 n_cmds, n_ticks, n_setups);
        $display("default, all-zero and short random timing, presence, stuck-low and busy requests");
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
